// File: hw/rtl/tmi_pkg.sv
// tmi_pkg: shared types, constants and the saturation helper of the
// triclinic minimum-image block. No dependencies.
package tmi_pkg;

  localparam int unsigned COORD_BITS   = 32;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned DIAG_BITS    = COORD_BITS - 1;
  localparam int unsigned NUM_BITS     = COORD_BITS + 1;
  localparam int unsigned QUOT_BITS    = COORD_BITS + 1;
  localparam int unsigned DIV_STEPS    = NUM_BITS;
  localparam int unsigned PROD_BITS    = QUOT_BITS + COORD_BITS;
  localparam int unsigned WIDE_BITS    = PROD_BITS + 1;
  localparam int unsigned CFG_IDX_BITS = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [DIAG_BITS-1:0]  diag_t;
  typedef logic signed [QUOT_BITS-1:0]  quot_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;

  // 1.0 in fixed point, reset value of the box diagonal
  localparam diag_t DIAG_ONE = diag_t'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BOX_AX = 3'd0,
    REG_BOX_BX = 3'd1,
    REG_BOX_BY = 3'd2,
    REG_BOX_CX = 3'd3,
    REG_BOX_CY = 3'd4,
    REG_BOX_CZ = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t first_z;
    coord_t second_x;
    coord_t second_y;
    coord_t second_z;
  } in_item_t;

  typedef struct packed {
    coord_t sep_x;
    coord_t sep_y;
    coord_t sep_z;
  } out_item_t;

  // clamp a wide signed value to the coordinate range
  function automatic coord_t sat_coord(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = {{(WIDE_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

// File: hw/rtl/tmi_in_if.sv
// tmi_in_if: valid/ready channel carrying one particle pair.
// Depends on tmi_pkg.
interface tmi_in_if;
  import tmi_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/tmi_out_if.sv
// tmi_out_if: valid/ready channel carrying one separation vector.
// Depends on tmi_pkg.
interface tmi_out_if;
  import tmi_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/triclinic_minimum_image.sv
// Triclinic minimum-image separation: one pair per cycle when not stalled
// (difference register, then for c, b and a in turn a 34-stage divider and a
// two-stage multiply-subtract). Full stages hold only while the next one stalls,
// so bubbles close up and a waiting result stops intake only once the pipeline
// is full. Write box registers only while idle; the block does not enforce it.
// Depends on tmi_pkg, tmi_in_if, tmi_out_if, tmi_divider and tmi_msub.
module triclinic_minimum_image (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tmi_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [tmi_pkg::COORD_BITS-1:0]        cfg_data_i,
  tmi_in_if.sink                                pair_i,
  tmi_out_if.source                             sep_o
);
  import tmi_pkg::*;

  diag_t  box_ax_q, box_by_q, box_cz_q;
  coord_t box_bx_q, box_cx_q, box_cy_q;

  logic   dif_vld_q;
  logic   dif_en;
  vec_t   dif_d;
  vec_t   dif_q;

  logic   dz_rdy, dz_vld, mz_rdy, mz_vld;
  logic   dy_rdy, dy_vld, my_rdy, my_vld;
  logic   dx_rdy, dx_vld, mx_rdy, mx_vld;
  vec_t   dz_vec, mz_vec, dy_vec, my_vec, dx_vec, mx_vec;
  quot_t  dz_n, dy_n, dx_n;
  vec_t   coef_c, coef_b, coef_a;

  // box registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_ax_q <= DIAG_ONE;
      box_bx_q <= '0;
      box_by_q <= DIAG_ONE;
      box_cx_q <= '0;
      box_cy_q <= '0;
      box_cz_q <= DIAG_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BOX_AX: box_ax_q <= cfg_data_i[DIAG_BITS-1:0];
        REG_BOX_BX: box_bx_q <= cfg_data_i;
        REG_BOX_BY: box_by_q <= cfg_data_i[DIAG_BITS-1:0];
        REG_BOX_CX: box_cx_q <= cfg_data_i;
        REG_BOX_CY: box_cy_q <= cfg_data_i;
        REG_BOX_CZ: box_cz_q <= cfg_data_i[DIAG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // saturated difference second - first
  always_comb begin
    dif_d.x = sat_coord(wide_t'(pair_i.data.second_x) - wide_t'(pair_i.data.first_x));
    dif_d.y = sat_coord(wide_t'(pair_i.data.second_y) - wide_t'(pair_i.data.first_y));
    dif_d.z = sat_coord(wide_t'(pair_i.data.second_z) - wide_t'(pair_i.data.first_z));
  end

  assign dif_en       = !dif_vld_q || dz_rdy;
  assign pair_i.ready = dif_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dif_vld_q <= 1'b0;
    end else if (dif_en) begin
      dif_vld_q <= pair_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dif_en) begin
      dif_q <= dif_d;
    end
  end

  // per-step coefficients, unused lanes get zero
  always_comb begin
    coef_c.x = box_cx_q;
    coef_c.y = box_cy_q;
    coef_c.z = coord_t'({1'b0, box_cz_q});
    coef_b.x = box_bx_q;
    coef_b.y = coord_t'({1'b0, box_by_q});
    coef_b.z = '0;
    coef_a.x = coord_t'({1'b0, box_ax_q});
    coef_a.y = '0;
    coef_a.z = '0;
  end

  // remove multiples of c
  tmi_divider u_div_c (
    .clk_i, .rst_ni,
    .in_valid_i (dif_vld_q), .in_ready_o (dz_rdy),
    .in_vec_i (dif_q), .in_num_i (dif_q.z), .den_i (box_cz_q),
    .out_valid_o (dz_vld), .out_ready_i (mz_rdy),
    .out_vec_o (dz_vec), .out_quot_o (dz_n)
  );
  tmi_msub u_msub_c (
    .clk_i, .rst_ni,
    .in_valid_i (dz_vld), .in_ready_o (mz_rdy),
    .in_vec_i (dz_vec), .in_quot_i (dz_n), .coef_i (coef_c),
    .out_valid_o (mz_vld), .out_ready_i (dy_rdy), .out_vec_o (mz_vec)
  );

  // remove multiples of b
  tmi_divider u_div_b (
    .clk_i, .rst_ni,
    .in_valid_i (mz_vld), .in_ready_o (dy_rdy),
    .in_vec_i (mz_vec), .in_num_i (mz_vec.y), .den_i (box_by_q),
    .out_valid_o (dy_vld), .out_ready_i (my_rdy),
    .out_vec_o (dy_vec), .out_quot_o (dy_n)
  );
  tmi_msub u_msub_b (
    .clk_i, .rst_ni,
    .in_valid_i (dy_vld), .in_ready_o (my_rdy),
    .in_vec_i (dy_vec), .in_quot_i (dy_n), .coef_i (coef_b),
    .out_valid_o (my_vld), .out_ready_i (dx_rdy), .out_vec_o (my_vec)
  );

  // remove multiples of a
  tmi_divider u_div_a (
    .clk_i, .rst_ni,
    .in_valid_i (my_vld), .in_ready_o (dx_rdy),
    .in_vec_i (my_vec), .in_num_i (my_vec.x), .den_i (box_ax_q),
    .out_valid_o (dx_vld), .out_ready_i (mx_rdy),
    .out_vec_o (dx_vec), .out_quot_o (dx_n)
  );
  tmi_msub u_msub_a (
    .clk_i, .rst_ni,
    .in_valid_i (dx_vld), .in_ready_o (mx_rdy),
    .in_vec_i (dx_vec), .in_quot_i (dx_n), .coef_i (coef_a),
    .out_valid_o (mx_vld), .out_ready_i (sep_o.ready), .out_vec_o (mx_vec)
  );

  // result channel
  assign sep_o.valid      = mx_vld;
  assign sep_o.data.sep_x = mx_vec.x;
  assign sep_o.data.sep_y = mx_vec.y;
  assign sep_o.data.sep_z = mx_vec.z;

endmodule

// File: hw/rtl/tmi_divider.sv
// tmi_divider: pipelined restoring divider, an entry register then one
// quotient bit per stage, giving round-half-away quotient of a coordinate by
// a box diagonal. Depends on tmi_pkg.
module tmi_divider (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tmi_pkg::vec_t   in_vec_i,
  input  tmi_pkg::coord_t in_num_i,
  input  tmi_pkg::diag_t  den_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tmi_pkg::vec_t   out_vec_o,
  output tmi_pkg::quot_t  out_quot_o
);
  import tmi_pkg::*;

  localparam int unsigned NST = DIV_STEPS + 1;

  logic [NST-1:0]        vld_q;
  logic [NST-1:0]        en;
  vec_t                  vec_q [NST];
  logic [NUM_BITS-1:0]   num_q [NST];
  logic [COORD_BITS-1:0] rem_q [NST];
  logic [QUOT_BITS-1:0]  quo_q [NST];
  logic                  neg_q [NST];
  logic                  zero_q [NST];

  logic [COORD_BITS-1:0] mag_in;
  logic [NUM_BITS-1:0]   num_in;
  logic [COORD_BITS-1:0] dd;
  logic [NUM_BITS-1:0]   sh_w  [NST];
  logic [NUM_BITS-1:0]   dif_w [NST];
  logic                  ge_w  [NST];
  logic [QUOT_BITS-1:0]  q_fin;

  // per-stage advance, a bubble lets upstream stages move
  always_comb begin
    en[NST-1] = !vld_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end
  assign in_ready_o = en[0];

  // entry: magnitude and numerator 2|v| + d, divisor 2d
  always_comb begin
    mag_in = in_num_i[COORD_BITS-1] ? (~in_num_i + 1'b1) : in_num_i;
    num_in = {mag_in, 1'b0} + {2'b00, den_i};
  end
  assign dd = {den_i, 1'b0};

  // one restoring step per stage
  always_comb begin
    sh_w[0]  = '0;
    dif_w[0] = '0;
    ge_w[0]  = 1'b0;
    for (int k = 1; k < NST; k++) begin
      sh_w[k]  = {rem_q[k-1], num_q[k-1][NUM_BITS-1]};
      dif_w[k] = sh_w[k] - {1'b0, dd};
      ge_w[k]  = sh_w[k] >= {1'b0, dd};
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      vec_q[0]  <= in_vec_i;
      num_q[0]  <= num_in;
      rem_q[0]  <= '0;
      quo_q[0]  <= '0;
      neg_q[0]  <= in_num_i[COORD_BITS-1];
      zero_q[0] <= (den_i == '0);
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        vec_q[k]  <= vec_q[k-1];
        num_q[k]  <= num_q[k-1] << 1;
        rem_q[k]  <= ge_w[k] ? dif_w[k][COORD_BITS-1:0] : sh_w[k][COORD_BITS-1:0];
        quo_q[k]  <= {quo_q[k-1][QUOT_BITS-2:0], ge_w[k]};
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  // signed multiple, zero for an empty diagonal
  always_comb begin
    q_fin = quo_q[NST-1];
    if (zero_q[NST-1]) begin
      out_quot_o = '0;
    end else if (neg_q[NST-1]) begin
      out_quot_o = quot_t'(~q_fin + 1'b1);
    end else begin
      out_quot_o = quot_t'(q_fin);
    end
  end

  assign out_valid_o = vld_q[NST-1];
  assign out_vec_o   = vec_q[NST-1];

endmodule

// File: hw/rtl/tmi_msub.sv
// tmi_msub: two-stage saturating multiply-subtract v - n*c on three lanes.
// Depends on tmi_pkg.
module tmi_msub (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tmi_pkg::vec_t  in_vec_i,
  input  tmi_pkg::quot_t in_quot_i,
  input  tmi_pkg::vec_t  coef_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tmi_pkg::vec_t  out_vec_o
);
  import tmi_pkg::*;

  logic   mul_vld_q;
  logic   sub_vld_q;
  logic   mul_en;
  logic   sub_en;
  vec_t   vec_q;
  prod_t  px_q, py_q, pz_q;
  prod_t  px_d, py_d, pz_d;
  vec_t   res_d;
  vec_t   res_q;

  assign sub_en     = !sub_vld_q || out_ready_i;
  assign mul_en     = !mul_vld_q || sub_en;
  assign in_ready_o = mul_en;

  // products, full width
  always_comb begin
    px_d = in_quot_i * coef_i.x;
    py_d = in_quot_i * coef_i.y;
    pz_d = in_quot_i * coef_i.z;
  end

  // subtract and clamp; an oversize product drives the lane to its limit
  always_comb begin
    res_d.x = sat_coord(wide_t'(vec_q.x) - wide_t'(px_q));
    res_d.y = sat_coord(wide_t'(vec_q.y) - wide_t'(py_q));
    res_d.z = sat_coord(wide_t'(vec_q.z) - wide_t'(pz_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sub_vld_q <= 1'b0;
    end else begin
      if (mul_en) begin
        mul_vld_q <= in_valid_i;
      end
      if (sub_en) begin
        sub_vld_q <= mul_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      vec_q <= in_vec_i;
      px_q  <= px_d;
      py_q  <= py_d;
      pz_q  <= pz_d;
    end
    if (sub_en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = sub_vld_q;
  assign out_vec_o   = res_q;

endmodule
